/* hw/rtl/sensor_reading_qualifier_defines.svh */
// Assertion macros used by the checker file srq_checker.sv.
`ifndef SENSOR_READING_QUALIFIER_DEFINES_SVH
`define SENSOR_READING_QUALIFIER_DEFINES_SVH

// Same-cycle implication, reset masks the check.
`define SRQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, reset masks the check.
`define SRQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/srq_pkg.sv */
package srq_pkg;

	localparam int VALUE_W = 16;
	localparam int PREC_W = 15;
	localparam int LIMIT_W = 48;
	localparam int ERR_CNT_W_DEF = 16;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PRECISION = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_VALUE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_THRESH = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THRESH = 3'd5;

	// Item actions
	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_CLEAR = 1'b1;

	// Alarm levels
	localparam int LVL_W = 3;
	localparam logic [LVL_W-1:0] LVL_NORMAL = 3'd0;
	localparam logic [LVL_W-1:0] LVL_NOTIFY_LOW = 3'd1;
	localparam logic [LVL_W-1:0] LVL_WARN_LOW = 3'd2;
	localparam logic [LVL_W-1:0] LVL_ALERT_LOW = 3'd3;
	localparam logic [LVL_W-1:0] LVL_NOTIFY_HIGH = 3'd4;
	localparam logic [LVL_W-1:0] LVL_WARN_HIGH = 3'd5;
	localparam logic [LVL_W-1:0] LVL_ALERT_HIGH = 3'd6;

	// Reset values of the configuration registers
	localparam logic signed [VALUE_W-1:0] RANGE_LOW_RST = 16'sh8000;
	localparam logic signed [VALUE_W-1:0] RANGE_HIGH_RST = 16'sh7FFF;
	localparam logic [PREC_W-1:0] PRECISION_RST = 15'd16;
	localparam logic signed [VALUE_W-1:0] DEFAULT_VALUE_RST = 16'sh0000;
	localparam logic signed [VALUE_W-1:0] LOW_LIMIT_RST = 16'sh8000;
	localparam logic signed [VALUE_W-1:0] HIGH_LIMIT_RST = 16'sh7FFF;

	typedef struct packed {
		logic action;
		logic signed [VALUE_W-1:0] sample;
		logic source_ok;
		logic bus_ready;
	} srq_in_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] shown_value;
		logic signed [VALUE_W-1:0] min_seen;
		logic signed [VALUE_W-1:0] max_seen;
		logic extremes_valid;
		logic [LVL_W-1:0] level;
		logic faulty;
		logic value_updated;
		logic level_changed;
	} srq_out_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] range_low;
		logic signed [VALUE_W-1:0] range_high;
		logic [PREC_W-1:0] precision;
		logic signed [VALUE_W-1:0] low_alert;
		logic signed [VALUE_W-1:0] low_warn;
		logic signed [VALUE_W-1:0] low_notify;
		logic signed [VALUE_W-1:0] high_alert;
		logic signed [VALUE_W-1:0] high_warn;
		logic signed [VALUE_W-1:0] high_notify;
	} srq_cfg_t;

	// Write of the default value, which also reloads the held value
	typedef struct packed {
		logic load;
		logic signed [VALUE_W-1:0] value;
	} srq_dv_wr_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] held;
		logic signed [VALUE_W-1:0] min_v;
		logic signed [VALUE_W-1:0] max_v;
		logic ext_set;
		logic [LVL_W-1:0] lvl;
	} srq_state_t;

endpackage

/* hw/rtl/srq_cfg_regs.sv */
module srq_cfg_regs (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	input  logic [srq_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [srq_pkg::LIMIT_W-1:0] wr_data,
	output srq_pkg::srq_cfg_t cfg,
	output srq_pkg::srq_dv_wr_t dv_wr
);

	srq_pkg::srq_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.range_low <= srq_pkg::RANGE_LOW_RST;
			cfg_q.range_high <= srq_pkg::RANGE_HIGH_RST;
			cfg_q.precision <= srq_pkg::PRECISION_RST;
			cfg_q.low_alert <= srq_pkg::LOW_LIMIT_RST;
			cfg_q.low_warn <= srq_pkg::LOW_LIMIT_RST;
			cfg_q.low_notify <= srq_pkg::LOW_LIMIT_RST;
			cfg_q.high_alert <= srq_pkg::HIGH_LIMIT_RST;
			cfg_q.high_warn <= srq_pkg::HIGH_LIMIT_RST;
			cfg_q.high_notify <= srq_pkg::HIGH_LIMIT_RST;
		end else if (wr_valid) begin
			unique case (wr_index)
				srq_pkg::CFG_RANGE_LOW: cfg_q.range_low <= wr_data[15:0];
				srq_pkg::CFG_RANGE_HIGH: cfg_q.range_high <= wr_data[15:0];
				srq_pkg::CFG_PRECISION: cfg_q.precision <= wr_data[14:0];
				srq_pkg::CFG_LOW_THRESH: begin
					cfg_q.low_alert <= wr_data[47:32];
					cfg_q.low_warn <= wr_data[31:16];
					cfg_q.low_notify <= wr_data[15:0];
				end
				srq_pkg::CFG_HIGH_THRESH: begin
					cfg_q.high_alert <= wr_data[47:32];
					cfg_q.high_warn <= wr_data[31:16];
					cfg_q.high_notify <= wr_data[15:0];
				end
				default: ; // default value goes straight to the held value; others ignored
			endcase
		end
	end

	assign cfg = cfg_q;
	assign dv_wr.load = wr_valid && (wr_index == srq_pkg::CFG_DEFAULT_VALUE);
	assign dv_wr.value = wr_data[15:0];

endmodule

/* hw/rtl/srq_update.sv */
module srq_update #(
	parameter int ERROR_COUNT_WIDTH = srq_pkg::ERR_CNT_W_DEF
) (
	input  srq_pkg::srq_in_t item,
	input  srq_pkg::srq_cfg_t cfg,
	input  srq_pkg::srq_state_t cur,
	input  logic [ERROR_COUNT_WIDTH-1:0] err_cnt,
	output srq_pkg::srq_state_t nxt,
	output logic [ERROR_COUNT_WIDTH-1:0] err_nxt,
	output srq_pkg::srq_out_t res
);

	logic signed [srq_pkg::VALUE_W+1:0] ss, rl, rh, pr, hv;
	logic healthy, rec_out, rng_out, hold_band, updated, changed;
	logic [srq_pkg::LVL_W-1:0] lvl;
	logic [ERROR_COUNT_WIDTH-1:0] err_bump;

	// Widen by two bits so sums with the precision cannot wrap
	assign ss = 18'(item.sample);
	assign rl = 18'(cfg.range_low);
	assign rh = 18'(cfg.range_high);
	assign pr = {3'b000, cfg.precision};
	assign hv = 18'(cur.held);

	assign healthy = (err_cnt == '0);
	assign err_bump = (&err_cnt) ? err_cnt : err_cnt + ERROR_COUNT_WIDTH'(1);
	assign rec_out = (ss < rl + pr) || (ss > rh - pr);
	assign rng_out = (item.sample < cfg.range_low) || (item.sample > cfg.range_high);
	assign hold_band = cur.ext_set && (ss < hv + pr) && (ss > hv - pr);

	always_comb begin
		priority if (item.sample < cfg.low_alert) lvl = srq_pkg::LVL_ALERT_LOW;
		else if (item.sample < cfg.low_warn) lvl = srq_pkg::LVL_WARN_LOW;
		else if (item.sample < cfg.low_notify) lvl = srq_pkg::LVL_NOTIFY_LOW;
		else if (item.sample > cfg.high_alert) lvl = srq_pkg::LVL_ALERT_HIGH;
		else if (item.sample > cfg.high_warn) lvl = srq_pkg::LVL_WARN_HIGH;
		else if (item.sample > cfg.high_notify) lvl = srq_pkg::LVL_NOTIFY_HIGH;
		else lvl = srq_pkg::LVL_NORMAL;
	end

	always_comb begin
		nxt = cur;
		err_nxt = err_cnt;
		updated = 1'b0;
		changed = 1'b0;
		if (item.action == srq_pkg::ACT_CLEAR) begin
			nxt.ext_set = 1'b0;
			nxt.min_v = '0;
			nxt.max_v = '0;
		end else if (item.bus_ready) begin
			priority if (!item.source_ok) begin
				if (healthy) err_nxt = err_bump;
			end else if (!healthy && rec_out) begin
				err_nxt = err_bump;
			end else if (healthy && rng_out) begin
				err_nxt = err_bump;
			end else if (healthy && hold_band) begin
				// small move: hold
			end else begin
				err_nxt = '0;
				nxt.held = item.sample;
				if (!cur.ext_set || item.sample < cur.min_v) nxt.min_v = item.sample;
				if (!cur.ext_set || item.sample > cur.max_v) nxt.max_v = item.sample;
				nxt.ext_set = 1'b1;
				updated = 1'b1;
				if (!healthy || lvl != cur.lvl) begin
					nxt.lvl = lvl;
					changed = 1'b1;
				end
			end
		end
	end

	assign res.shown_value = nxt.held;
	assign res.min_seen = nxt.min_v;
	assign res.max_seen = nxt.max_v;
	assign res.extremes_valid = nxt.ext_set;
	assign res.level = nxt.lvl;
	assign res.faulty = (err_nxt != '0);
	assign res.value_updated = updated;
	assign res.level_changed = changed;

endmodule

/* hw/rtl/sensor_reading_qualifier.sv */
// Sensor reading qualifier: screens one sensor channel's Q11.4 samples.
// Channels:
//   sample_* : valid/ready input of items (action, sample, source_ok, bus_ready).
//   result_* : valid/ready output, exactly one result item per input item,
//              showing the channel state after that item.
//   cfg_*    : valid/ready register writes (index, data); cfg_ready is always
//              high. Write only while the block holds no unfinished item.
// Timing: an accepted item is held in the input register, passes the
// combinational update and is then presented from the result register,
// where it waits until result_ready takes it.
// Throughput: one item per cycle while results are taken; the state update
// is a single compare-and-select pass between input and result registers.
// Reset: all but the payload registers reset; the channel starts
// faulty (error count one), held value zero, extremes invalid, level normal.
// Stall: while a result waits and result_ready is low the result register
// holds; one more item waits in the input register, then sample_ready drops.
module sensor_reading_qualifier #(
	parameter int ERROR_COUNT_WIDTH = srq_pkg::ERR_CNT_W_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic sample_valid,
	output logic sample_ready,
	input  srq_pkg::srq_in_t sample_item,
	output logic result_valid,
	input  logic result_ready,
	output srq_pkg::srq_out_t result_item,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [srq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [srq_pkg::LIMIT_W-1:0] cfg_data
);

	srq_pkg::srq_in_t item_s1;
	logic valid_s1;
	logic advance;

	srq_pkg::srq_state_t state_q, state_nxt;
	logic [ERROR_COUNT_WIDTH-1:0] err_q, err_nxt;
	srq_pkg::srq_out_t res_nxt, res_q;
	logic res_valid_q;

	srq_pkg::srq_cfg_t cfg;
	srq_pkg::srq_dv_wr_t dv_wr;

	assign cfg_ready = 1'b1;

	srq_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg),
		.dv_wr    (dv_wr)
	);

	// Advance the item in the input register whenever the result register
	// is empty or being emptied this cycle.
	assign advance = valid_s1 && (!res_valid_q || result_ready);
	assign sample_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	// Payload register: no reset needed
	always_ff @(posedge clk) begin
		if (sample_valid && sample_ready) begin
			item_s1 <= sample_item;
		end
	end

	srq_update #(
		.ERROR_COUNT_WIDTH (ERROR_COUNT_WIDTH)
	) u_update (
		.item    (item_s1),
		.cfg     (cfg),
		.cur     (state_q),
		.err_cnt (err_q),
		.nxt     (state_nxt),
		.err_nxt (err_nxt),
		.res     (res_nxt)
	);

	// Channel state: take the next state on each advanced item; a write of the
	// default value reloads the held value (user writes only when idle; unenforced).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.held <= srq_pkg::DEFAULT_VALUE_RST;
			state_q.min_v <= '0;
			state_q.max_v <= '0;
			state_q.ext_set <= 1'b0;
			state_q.lvl <= srq_pkg::LVL_NORMAL;
			err_q <= ERROR_COUNT_WIDTH'(1);
		end else if (advance) begin
			state_q <= state_nxt;
			err_q <= err_nxt;
		end else if (dv_wr.load) begin
			state_q.held <= dv_wr.value;
		end
	end

	// Result register: fill on advance, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign result_valid = res_valid_q;
	assign result_item = res_q;

endmodule

/* hw/rtl/srq_checker.sv */
`include "sensor_reading_qualifier_defines.svh"

module srq_checker (
	input logic clk,
	input logic arst_n,
	input logic result_valid,
	input logic result_ready,
	input srq_pkg::srq_out_t result_item
);

	// Hold a stalled result item
	`SRQ_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(result_item), "stalled result item changed")

	// An accepted value always clears the fault
	`SRQ_ASSERT_NOW(a_update_healthy, clk, arst_n, result_valid && result_item.value_updated, !result_item.faulty, "updated value on a faulty channel")

	// A level change only comes with a new value
	`SRQ_ASSERT_NOW(a_change_needs_update, clk, arst_n, result_valid && result_item.level_changed, result_item.value_updated, "level changed without update")

	// Invalid extremes read as zero
	`SRQ_ASSERT_NOW(a_extremes_zero, clk, arst_n, result_valid && !result_item.extremes_valid, result_item.min_seen == '0 && result_item.max_seen == '0, "extremes not zero while invalid")

	// Valid extremes are ordered
	`SRQ_ASSERT_NOW(a_extremes_order, clk, arst_n, result_valid && result_item.extremes_valid, result_item.min_seen <= result_item.max_seen, "minimum above maximum")

endmodule

bind sensor_reading_qualifier srq_checker u_srq_checker (.*);
